// ===== design/wsd_pkg.sv =====
// shared types and constants for the websocket frame deframer
`timescale 1ns / 1ps

package wsd_pkg;

  // frame opcodes
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'h7E;
  localparam logic [6:0] LEN_EXT64 = 7'h7F;

  localparam int unsigned MASK_BYTES = 4;
  localparam int unsigned MASK_IDX_W = $clog2(MASK_BYTES);

  typedef enum logic [2:0] {
    ACT_FRAGMENT    = 3'd0,
    ACT_PING        = 3'd1,
    ACT_PONG        = 3'd2,
    ACT_MESSAGE     = 3'd3,
    ACT_CLOSE_ECHO  = 3'd4,
    ACT_CLOSE_QUIET = 3'd5,
    ACT_IGNORED     = 3'd6
  } action_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [3:0] opcode;
    logic       final_fragment;
    logic       last_of_frame;
    logic       empty_frame;
    action_t    action;
    logic       completes_message;
  } wsd_result_t;

endpackage

// ===== design/wsd_ifs.sv =====
// byte and result channel interfaces
`timescale 1ns / 1ps

interface wsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsd_res_if import wsd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [3:0] opcode;
  logic       final_fragment;
  logic       last_of_frame;
  logic       empty_frame;
  logic [2:0] action;
  logic       completes_message;

  modport source (output valid, output payload_byte, output opcode, output final_fragment,
                  output last_of_frame, output empty_frame, output action,
                  output completes_message, input ready);
  modport sink (input valid, input payload_byte, input opcode, input final_fragment,
                input last_of_frame, input empty_frame, input action,
                input completes_message, output ready);
endinterface

// ===== design/wsd_parser.sv =====
// frame parse state and per-byte result logic
`timescale 1ns / 1ps

module wsd_parser import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  input  logic        link_open,
  output logic        emit,
  output wsd_result_t result
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_MASK,
    PH_DATA
  } phase_t;

  phase_t                phase, phase_next;
  logic                  fin_bit, fin_bit_next;
  logic [3:0]            frame_opcode, frame_opcode_next;
  logic                  mask_present, mask_present_next;
  logic                  len_long, len_long_next;
  logic [2:0]            hdr_count, hdr_count_next;
  logic [63:0]           length_left, length_left_next;
  logic [7:0]            mask_key [MASK_BYTES];
  logic [MASK_IDX_W-1:0] mask_idx, mask_idx_next;
  logic                  fragment_pending, fragment_pending_next;

  logic                  key_we;
  logic [2:0]            count_inc;
  logic                  do_after, do_done, do_finish, mask_sel;
  logic [63:0]           len_val;
  logic                  is_frag;
  action_t               act;

  assign is_frag = !fin_bit || (frame_opcode == OP_CONT);

  always_comb begin
    if (is_frag) begin
      act = ACT_FRAGMENT;
    end else begin
      case (frame_opcode)
        OP_PING:          act = ACT_PING;
        OP_PONG:          act = ACT_PONG;
        OP_TEXT, OP_BIN:  act = ACT_MESSAGE;
        OP_CLOSE:         act = link_open ? ACT_CLOSE_ECHO : ACT_CLOSE_QUIET;
        default:          act = ACT_IGNORED;
      endcase
    end
  end

  always_comb begin
    phase_next            = phase;
    fin_bit_next          = fin_bit;
    frame_opcode_next     = frame_opcode;
    mask_present_next     = mask_present;
    len_long_next         = len_long;
    hdr_count_next        = hdr_count;
    length_left_next      = length_left;
    mask_idx_next         = mask_idx;
    fragment_pending_next = fragment_pending;
    key_we                = 1'b0;
    count_inc             = hdr_count + 3'd1;
    do_after              = 1'b0;
    do_done               = 1'b0;
    do_finish             = 1'b0;
    mask_sel              = mask_present;
    len_val               = length_left;
    emit                  = 1'b0;

    result.payload_byte      = rx_byte;
    result.opcode            = frame_opcode;
    result.final_fragment    = fin_bit;
    result.last_of_frame     = 1'b0;
    result.empty_frame       = 1'b0;
    result.action            = act;
    result.completes_message = !is_frag && fragment_pending;

    if (accept) begin
      unique case (phase)
        PH_HDR0: begin
          fin_bit_next      = rx_byte[7];
          frame_opcode_next = rx_byte[3:0];
          phase_next        = PH_HDR1;
        end
        PH_HDR1: begin
          mask_present_next = rx_byte[7];
          mask_sel          = rx_byte[7];
          hdr_count_next    = 3'd0;
          if (rx_byte[6:0] == LEN_EXT16 || rx_byte[6:0] == LEN_EXT64) begin
            len_long_next    = (rx_byte[6:0] == LEN_EXT64);
            length_left_next = '0;
            phase_next       = PH_EXT;
          end else begin
            len_val          = 64'(rx_byte[6:0]);
            length_left_next = len_val;
            do_after         = 1'b1;
          end
        end
        PH_EXT: begin
          len_val          = {length_left[55:0], rx_byte};
          length_left_next = len_val;
          hdr_count_next   = count_inc;
          // 64-bit length ends when the 3-bit count wraps
          if (len_long ? (count_inc == 3'd0) : (count_inc >= 3'd2)) begin
            do_after = 1'b1;
          end
        end
        PH_MASK: begin
          key_we         = 1'b1;
          hdr_count_next = count_inc;
          if (count_inc[2]) begin
            hdr_count_next = 3'd0;
            do_done        = 1'b1;
          end
        end
        PH_DATA: begin
          emit = 1'b1;
          if (mask_present) begin
            result.payload_byte = rx_byte ^ mask_key[mask_idx];
          end
          result.last_of_frame = (length_left == 64'd1);
          length_left_next     = length_left - 64'd1;
          mask_idx_next        = mask_idx + 1'b1;
          if (length_left == 64'd1) begin
            do_finish = 1'b1;
          end
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase

      if (do_after) begin
        hdr_count_next = 3'd0;
        if (mask_sel) begin
          phase_next = PH_MASK;
        end else begin
          do_done = 1'b1;
        end
      end

      if (do_done) begin
        mask_idx_next = '0;
        if (len_val == 64'd0) begin
          // empty frame: one result with no payload
          emit                 = 1'b1;
          result.payload_byte  = 8'd0;
          result.last_of_frame = 1'b1;
          result.empty_frame   = 1'b1;
          do_finish            = 1'b1;
        end else begin
          phase_next = PH_DATA;
        end
      end

      if (do_finish) begin
        phase_next = PH_HDR0;
        if (is_frag) begin
          if (!result.empty_frame) begin
            fragment_pending_next = 1'b1;
          end
        end else begin
          fragment_pending_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HDR0;
      fin_bit          <= 1'b0;
      frame_opcode     <= OP_CONT;
      mask_present     <= 1'b0;
      len_long         <= 1'b0;
      hdr_count        <= 3'd0;
      length_left      <= '0;
      mask_idx         <= '0;
      fragment_pending <= 1'b0;
      for (int i = 0; i < MASK_BYTES; i++) begin
        mask_key[i] <= 8'd0;
      end
    end else begin
      phase            <= phase_next;
      fin_bit          <= fin_bit_next;
      frame_opcode     <= frame_opcode_next;
      mask_present     <= mask_present_next;
      len_long         <= len_long_next;
      hdr_count        <= hdr_count_next;
      length_left      <= length_left_next;
      mask_idx         <= mask_idx_next;
      fragment_pending <= fragment_pending_next;
      if (key_we) begin
        mask_key[hdr_count[MASK_IDX_W-1:0]] <= rx_byte;
      end
    end
  end

endmodule

// ===== design/websocket_frame_deframer_core.sv =====
// top level of the websocket frame deframer
`timescale 1ns / 1ps

//  channel    dir   handshake        payload
//  rx         in    valid / ready    rx_byte
//  res        out   valid / ready    payload_byte, opcode, final_fragment, last_of_frame,
//                                    empty_frame, action, completes_message
//  cfg        in    cfg_wr_en        cfg_wr_data (link_open)
//
//  one byte per cycle while res is not stalled; a result shows up in the cycle after its byte is taken
//  header bytes give no result; each payload byte gives one, an empty frame gives one
//  the output register frees the input side: rx is ready while res is empty or being taken
//  synchronous active-high reset; link_open comes out of reset set

module websocket_frame_deframer_core import wsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  wsd_byte_if.sink   rx,
  wsd_res_if.source  res
);

  logic        link_open;
  logic        accept;
  logic        emit;
  wsd_result_t result;
  wsd_result_t res_q;
  logic        res_valid;

  // take a new byte whenever the result register can move on this cycle
  assign rx.ready = !res_valid || res.ready;
  assign accept   = rx.valid && rx.ready;

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx.rx_byte),
    .link_open (link_open),
    .emit      (emit),
    .result    (result)
  );

  // config register; the user must write it only while the block is idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      link_open <= 1'b1;
    end else if (cfg_wr_en) begin
      link_open <= cfg_wr_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && emit) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_q <= result;
    end
  end

  assign res.valid             = res_valid;
  assign res.payload_byte      = res_q.payload_byte;
  assign res.opcode            = res_q.opcode;
  assign res.final_fragment    = res_q.final_fragment;
  assign res.last_of_frame     = res_q.last_of_frame;
  assign res.empty_frame       = res_q.empty_frame;
  assign res.action            = res_q.action;
  assign res.completes_message = res_q.completes_message;

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the websocket frame deframer core
`timescale 1ns / 1ps

module tb;
  import wsd_pkg::*;

  // run control
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 4;      // result register is one stage deep
  localparam int RX_HOLD_CYCLES = 48;     // long receiver hold-off, long enough to back up rx
  localparam int CYCLE_LIMIT    = 100000; // several times the slowest legal run
  localparam int MAX_REPORTS    = 10;
  localparam int DIRECTED_ROWS  = 30;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  wsd_byte_if rx_ch ();
  wsd_res_if  res_ch ();

  websocket_frame_deframer_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rx          (rx_ch),
    .res         (res_ch)
  );

  // one stimulus item: the byte, the link_open value it runs under, and an optional
  // hand-written result that replaces the predicted one
  typedef struct packed {
    logic        link;
    logic [7:0]  data;
    logic        has_want;
    wsd_result_t want;
  } stim_row_t;

  // where the frame parser stands
  typedef enum logic [2:0] {
    STEP_HDR0,
    STEP_HDR1,
    STEP_EXT,
    STEP_MASK,
    STEP_DATA
  } parse_step_t;

  // directed frames: every action class, the fragment/complete pairing, the 64-bit
  // length path, a masked payload and both link_open settings for close
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // empty ping
    '{1'b1, 8'h89, 1'b0, '0},
    '{1'b1, 8'h00, 1'b1, '{8'h00, OP_PING, 1'b1, 1'b1, 1'b1, ACT_PING, 1'b0}},
    // empty pong
    '{1'b1, 8'h8A, 1'b0, '0},
    '{1'b1, 8'h00, 1'b1, '{8'h00, OP_PONG, 1'b1, 1'b1, 1'b1, ACT_PONG, 1'b0}},
    // empty close while the link is open: echoed
    '{1'b1, 8'h88, 1'b0, '0},
    '{1'b1, 8'h00, 1'b1, '{8'h00, OP_CLOSE, 1'b1, 1'b1, 1'b1, ACT_CLOSE_ECHO, 1'b0}},
    // all-ones header byte: reserved bits set, unknown opcode
    '{1'b1, 8'hFF, 1'b0, '0},
    '{1'b1, 8'h00, 1'b1, '{8'h00, 4'hF, 1'b1, 1'b1, 1'b1, ACT_IGNORED, 1'b0}},
    // masked text fragment, fin clear, one byte, all-ones key
    '{1'b1, 8'h01, 1'b0, '0},
    '{1'b1, 8'h81, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b0, '0},
    '{1'b1, 8'h00, 1'b1, '{8'hFF, OP_TEXT, 1'b0, 1'b1, 1'b0, ACT_FRAGMENT, 1'b0}},
    // final binary frame after the fragment: completes the message
    '{1'b1, 8'h82, 1'b0, '0},
    '{1'b1, 8'h01, 1'b0, '0},
    '{1'b1, 8'h5A, 1'b1, '{8'h5A, OP_BIN, 1'b1, 1'b1, 1'b0, ACT_MESSAGE, 1'b1}},
    // text frame with a 64-bit extended length of zero
    '{1'b1, 8'h81, 1'b0, '0},
    '{1'b1, 8'h7F, 1'b0, '0},
    '{1'b1, 8'h00, 1'b0, '0},
    '{1'b1, 8'h00, 1'b0, '0},
    '{1'b1, 8'h00, 1'b0, '0},
    '{1'b1, 8'h00, 1'b0, '0},
    '{1'b1, 8'h00, 1'b0, '0},
    '{1'b1, 8'h00, 1'b0, '0},
    '{1'b1, 8'h00, 1'b0, '0},
    '{1'b1, 8'h00, 1'b1, '{8'h00, OP_TEXT, 1'b1, 1'b1, 1'b1, ACT_MESSAGE, 1'b0}},
    // close with the link closed: no echo
    '{1'b0, 8'h88, 1'b0, '0},
    '{1'b0, 8'h00, 1'b1, '{8'h00, OP_CLOSE, 1'b1, 1'b1, 1'b1, ACT_CLOSE_QUIET, 1'b0}}
  };

  // deframer shadow state
  parse_step_t parse_step;
  logic        hdr_fin;
  logic [3:0]  hdr_opcode;
  logic        hdr_masked;
  logic [6:0]  hdr_len7;
  logic [2:0]  hdr_count;
  logic [63:0] frame_len;
  logic [7:0]  mask_bytes [4];
  logic [63:0] data_index;
  logic        frag_open;
  logic        link_open_now;

  wsd_result_t frames_expected [$];
  stim_row_t   pending_bytes [$];

  // run bookkeeping
  bit          src_gaps;
  bit          sink_gaps;
  bit          stall_request;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned bytes_sent;
  int unsigned results_checked;
  int unsigned empty_results;
  int unsigned joined_results;
  logic [7:0]  actions_seen;
  logic [1:0]  links_written;

  function automatic bit frame_is_fragment();
    return !hdr_fin || hdr_opcode == OP_CONT;
  endfunction

  function automatic action_t frame_action();
    if (frame_is_fragment()) return ACT_FRAGMENT;
    case (hdr_opcode)
      OP_PING:         return ACT_PING;
      OP_PONG:         return ACT_PONG;
      OP_TEXT, OP_BIN: return ACT_MESSAGE;
      OP_CLOSE:        return link_open_now ? ACT_CLOSE_ECHO : ACT_CLOSE_QUIET;
      default:         return ACT_IGNORED;
    endcase
  endfunction

  function automatic wsd_result_t frame_result(logic [7:0] b, logic last, logic empty);
    wsd_result_t r;
    r.payload_byte      = b;
    r.opcode            = hdr_opcode;
    r.final_fragment    = hdr_fin;
    r.last_of_frame     = last;
    r.empty_frame       = empty;
    r.action            = frame_action();
    r.completes_message = !frame_is_fragment() && frag_open;
    return r;
  endfunction

  // a fragment with payload leaves a message open; any final frame closes it
  function automatic void close_frame();
    if (frame_is_fragment()) begin
      if (frame_len != 64'd0) frag_open = 1'b1;
    end else begin
      frag_open = 1'b0;
    end
    parse_step = STEP_HDR0;
  endfunction

  // header fully read: zero length answers at once, else payload follows
  function automatic bit enter_payload(output wsd_result_t r);
    r = '0;
    data_index = '0;
    if (frame_len == 64'd0) begin
      r = frame_result(8'h00, 1'b1, 1'b1);
      close_frame();
      return 1'b1;
    end
    parse_step = STEP_DATA;
    return 1'b0;
  endfunction

  function automatic bit length_done(output wsd_result_t r);
    r = '0;
    hdr_count = '0;
    if (hdr_masked) begin
      parse_step = STEP_MASK;
      return 1'b0;
    end
    return enter_payload(r);
  endfunction

  // consume one received byte, return 1 with the result it causes
  function automatic bit deframe_byte(input logic [7:0] b, output wsd_result_t r);
    bit          got;
    logic [63:0] next_index;
    logic        last;
    got = 1'b0;
    r = '0;
    case (parse_step)
      STEP_HDR0: begin
        hdr_fin    = b[7];
        hdr_opcode = b[3:0];
        parse_step = STEP_HDR1;
      end
      STEP_HDR1: begin
        hdr_masked = b[7];
        hdr_len7   = b[6:0];
        hdr_count  = '0;
        if (hdr_len7 == LEN_EXT16 || hdr_len7 == LEN_EXT64) begin
          frame_len  = '0;
          parse_step = STEP_EXT;
        end else begin
          frame_len = 64'(hdr_len7);
          got = length_done(r);
        end
      end
      STEP_EXT: begin
        // big-endian; the 3-bit count wraps to zero after the eighth byte
        frame_len = {frame_len[55:0], b};
        hdr_count = hdr_count + 3'd1;
        if (hdr_count == 3'd0 || (hdr_len7 == LEN_EXT16 && hdr_count == 3'd2))
          got = length_done(r);
      end
      STEP_MASK: begin
        mask_bytes[hdr_count[1:0]] = b;
        hdr_count = hdr_count + 3'd1;
        if (hdr_count == 3'(MASK_BYTES)) begin
          hdr_count = '0;
          got = enter_payload(r);
        end
      end
      STEP_DATA: begin
        next_index = data_index + 64'd1;
        last = (next_index == frame_len);
        r = frame_result(hdr_masked ? b ^ mask_bytes[data_index[1:0]] : b, last, 1'b0);
        data_index = next_index;
        if (last) close_frame();
        got = 1'b1;
      end
      default: parse_step = STEP_HDR0;
    endcase
    return got;
  endfunction

  function automatic void reset_shadow();
    parse_step    = STEP_HDR0;
    hdr_fin       = 1'b0;
    hdr_opcode    = '0;
    hdr_masked    = 1'b0;
    hdr_len7      = '0;
    hdr_count     = '0;
    frame_len     = '0;
    data_index    = '0;
    frag_open     = 1'b0;
    link_open_now = 1'b1;
    for (int i = 0; i < 4; i++) mask_bytes[i] = '0;
  endfunction

  function automatic string show(wsd_result_t r);
    return $sformatf("byte %h op %h fin %b last %b empty %b act %0d join %b",
                     r.payload_byte, r.opcode, r.final_fragment, r.last_of_frame,
                     r.empty_frame, r.action, r.completes_message);
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  function automatic void push_byte(logic [7:0] b);
    pending_bytes.push_back('{link: link_open_now, data: b, has_want: 1'b0, want: '0});
  endfunction

  // random frame: mostly known opcodes and short payloads, some extended lengths,
  // some reserved bits and unknown opcodes as noise
  function automatic void queue_random_frame();
    logic [3:0]  op;
    logic        fin;
    logic        masked;
    logic [2:0]  rsv;
    logic [6:0]  len7;
    logic [63:0] len;
    logic [31:0] key;
    int unsigned pick;
    int          ext_bytes;
    if ($urandom_range(0, 19) < 17) begin
      case ($urandom_range(0, 5))
        0:       op = OP_CONT;
        1:       op = OP_TEXT;
        2:       op = OP_BIN;
        3:       op = OP_CLOSE;
        4:       op = OP_PING;
        default: op = OP_PONG;
      endcase
    end else begin
      op = 4'($urandom_range(0, 15));
    end
    fin    = ($urandom_range(0, 3) != 0);
    rsv    = ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'b000;
    masked = 1'($urandom_range(0, 1));
    key    = $urandom;
    pick   = $urandom_range(0, 99);
    ext_bytes = 0;
    if (pick < 70) begin
      len = 64'($urandom_range(0, 12));
    end else if (pick < 75) begin
      len = $urandom_range(0, 1) ? 64'd125 : 64'($urandom_range(13, 125));
    end else if (pick < 88) begin
      len = 64'($urandom_range(0, 40));
      ext_bytes = 2;
    end else begin
      len = 64'($urandom_range(0, 40));
      ext_bytes = 8;
    end
    len7 = (ext_bytes == 2) ? LEN_EXT16 : (ext_bytes == 8) ? LEN_EXT64 : len[6:0];
    push_byte({fin, rsv, op});
    push_byte({masked, len7});
    for (int i = ext_bytes - 1; i >= 0; i--) push_byte(len[8*i +: 8]);
    if (masked) begin
      for (int i = 3; i >= 0; i--) push_byte(key[8*i +: 8]);
    end
    for (longint i = 0; i < longint'(len); i++) push_byte(8'($urandom));
  endfunction

  function automatic void queue_random_bytes(int budget);
    while (pending_bytes.size() < budget) queue_random_frame();
  endfunction

  // offer one item, wait for it to be taken, then predict what it causes;
  // entered and left on a rising edge
  task automatic send_row(stim_row_t row);
    wsd_result_t r;
    bit          got;
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= row.data;
    do @(posedge clk); while (!rx_ch.ready);
    got = deframe_byte(row.data, r);
    if (got) frames_expected.push_back(row.has_want ? row.want : r);
    bytes_sent++;
  endtask

  task automatic send_pending();
    while (pending_bytes.size() != 0) send_row(pending_bytes.pop_front());
  endtask

  // stop offering and let every outstanding result drain
  task automatic pause_sender();
    rx_ch.valid <= 1'b0;
    while (frames_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_link(logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    link_open_now = v;
    links_written[v] = 1'b1;
  endtask

  // one random stretch under a fresh link_open value, started from idle
  task automatic random_phase(logic link, int budget, bit hold_rx);
    pause_sender();
    write_link(link);
    queue_random_bytes(budget);
    if (hold_rx) stall_request = 1'b1;
    send_pending();
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL websocket_frame_deframer_core");
      $finish;
    end
  end

  // result side: random short hold-offs, plus one long hold when asked for
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // compare every taken result with the oldest prediction
  always @(posedge clk) begin : check_results
    wsd_result_t seen;
    wsd_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen.payload_byte      = res_ch.payload_byte;
      seen.opcode            = res_ch.opcode;
      seen.final_fragment    = res_ch.final_fragment;
      seen.last_of_frame     = res_ch.last_of_frame;
      seen.empty_frame       = res_ch.empty_frame;
      seen.action            = action_t'(res_ch.action);
      seen.completes_message = res_ch.completes_message;
      if (frames_expected.size() == 0) begin
        note_failure({"result with nothing expected: ", show(seen)});
      end else begin
        want = frames_expected.pop_front();
        if (seen.payload_byte !== want.payload_byte || seen.opcode !== want.opcode
            || seen.final_fragment !== want.final_fragment
            || seen.last_of_frame !== want.last_of_frame
            || seen.empty_frame !== want.empty_frame || seen.action !== want.action
            || seen.completes_message !== want.completes_message)
          note_failure({"exp ", show(want), " got ", show(seen)});
        results_checked++;
        if (want.empty_frame) empty_results++;
        if (want.completes_message) joined_results++;
        actions_seen[want.action] = 1'b1;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 1'b0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    src_gaps      = 1'b1;
    sink_gaps     = 1'b1;
    stall_request = 1'b0;
    actions_seen  = '0;
    links_written = '0;
    reset_shadow();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed table; a change of link_open waits for the block to go idle
    foreach (directed_rows[i]) begin
      if (directed_rows[i].link != link_open_now) begin
        pause_sender();
        write_link(directed_rows[i].link);
      end
      send_row(directed_rows[i]);
    end

    // random stretches: the second opens with a long receiver hold-off while
    // bytes keep coming; the third runs with no idling on either side
    random_phase(1'b1, 300, 1'b0);
    random_phase(1'b0, 300, 1'b1);
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    random_phase(1'b1, 250, 1'b0);
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    random_phase(1'b0, 150, 1'b0);

    // closing part, no idling: a few frames, then a masked frame with an all-ones
    // 64-bit length that stays open to the end
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    queue_random_bytes(50);
    push_byte({1'b1, 3'b000, OP_BIN});
    push_byte({1'b1, LEN_EXT64});
    repeat (8) push_byte(8'hFF);
    repeat (MASK_BYTES) push_byte(8'($urandom));
    repeat (60) push_byte(8'($urandom));
    send_pending();

    pause_sender();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (frames_expected.size() != 0)
      note_failure($sformatf("%0d results never arrived", frames_expected.size()));

    $display("run: %0d bytes in, %0d results checked, %0d empty frames, %0d joined messages",
             bytes_sent, results_checked, empty_results, joined_results);
    $display("run: action classes seen %b, link_open written %b, %0d mismatches",
             actions_seen[6:0], links_written, fail_count);
    if (fail_count == 0) begin
      $display("PASS websocket_frame_deframer_core");
    end else begin
      $display("FAIL websocket_frame_deframer_core");
    end
    $finish;
  end

endmodule
